// File: sv/pidc_pkg.sv
`timescale 1ns / 1ps

package pidc_pkg;

   // time step format, unsigned Q8.24
   localparam int DT_W    = 32;
   localparam int DT_FRAC = 24;

   // operation code, carried on tuser
   localparam int OP_W        = 2;
   localparam int OP_NEG_BIT  = 0;
   localparam int OP_RATE_BIT = 1;

   // register file indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_UPPER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_LOWER = 3'd4;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL1,
      ST_MUL2,
      ST_DLOAD,
      ST_DMUL,
      ST_ACC,
      ST_CLAMP,
      ST_SUM,
      ST_CMD,
      ST_DONE
   } pidc_state_type;

endpackage

// File: sv/pidc_mul.sv
`timescale 1ns / 1ps

// unsigned shift-add multiplier, one multiplier bit per cycle
module pidc_mul #(
   parameter int A_W = 64,
   parameter int B_W = 32
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     mcand,
   input  logic [B_W-1:0]     mplier,
   output logic               busy,
   output logic [A_W+B_W-1:0] product
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic [A_W-1:0]     mcand_ff, mcand_in;
   logic [A_W+B_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic [A_W:0]       part;

   // add multiplicand to the upper half when the low bit is set, then shift right
   always_comb begin
      part     = {1'b0, prod_ff[A_W+B_W-1:B_W]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (start) begin
         mcand_in = mcand;
         prod_in  = {{A_W{1'b0}}, mplier};
         cnt_in   = CNT_W'(B_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         prod_in = {part, prod_ff[B_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operands and product
   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
   end

   assign busy    = busy_ff;
   assign product = prod_ff;

endmodule

// File: sv/pidc_div.sv
`timescale 1ns / 1ps

// unsigned restoring divider, one quotient bit per cycle
module pidc_div #(
   parameter int N_W = 57,
   parameter int D_W = 32
)(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] num,
   input  logic [D_W-1:0] den,
   output logic           busy,
   output logic [N_W-1:0] quot
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic [D_W-1:0]   den_ff, den_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [N_W-1:0]   nq_ff, nq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [D_W:0]     shifted;
   logic [D_W+1:0]   trial;
   logic             fits;

   // numerator bits leave at the top, quotient bits enter at the bottom
   always_comb begin
      shifted = {rem_ff, nq_ff[N_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      fits    = ~trial[D_W+1];
      den_in  = den_ff;
      rem_in  = rem_ff;
      nq_in   = nq_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         den_in  = den;
         rem_in  = '0;
         nq_in   = num;
         cnt_in  = CNT_W'(N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[D_W-1:0] : shifted[D_W-1:0];
         nq_in   = {nq_ff[N_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operands, remainder and quotient
   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      nq_ff  <= nq_in;
   end

   assign busy = busy_ff;
   assign quot = nq_ff;

endmodule

// File: sv/pid_controller_iclamp_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// req       in         req_tvalid/tready     error_in, error_rate, step_time; operation on tuser
// rsp       out        rsp_tvalid/tready     command, prop_error_out, integ_term_out, deriv_error_out
// csr       in         csr_wr_en             csr_addr selects the register, csr_wdata the value
//
// one request at a time; a request with nonzero step_time is paced by three bit-serial
// multiply passes in series, and the serial divide runs beside the first two. a zero
// step_time request goes straight to the result.
// reset is synchronous and clears the registers and the loop state to zero.
// the result register holds while rsp_tready is low and the next request is still taken.
module pid_controller_iclamp_top
   import pidc_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   localparam int REQ_TD_W  = ((2 * DATA_WIDTH + DT_W + 7) / 8) * 8,
   localparam int RSP_TD_W  = ((4 * DATA_WIDTH + 7) / 8) * 8
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_TD_W-1:0]   req_tdata,   // error_in, error_rate, step_time
   input  logic [OP_W-1:0]       req_tuser,   // operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_TD_W-1:0]   rsp_tdata,   // command, prop_error_out, integ_term_out,
                                              // deriv_error_out
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [DATA_WIDTH-1:0] csr_wdata
);

   localparam int W      = DATA_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int MI_A   = 2 * W;
   localparam int MI_B   = (W > DT_W) ? W : DT_W;
   localparam int MI_P   = MI_A + MI_B;
   localparam int INC_S  = F + DT_FRAC;
   localparam int INC_W  = MI_P - INC_S + 1;
   localparam int ACC_W  = ((INC_W > W) ? INC_W : W) + 2;
   localparam int PD_P   = 2 * W;
   localparam int PMAG_W = PD_P - F + 1;
   localparam int PT_W   = PMAG_W + 1;
   localparam int SUM_W  = ((PT_W > W) ? PT_W : W) + 2;
   localparam int NEG_W  = SUM_W + 1;
   localparam int N_W    = W + 1 + DT_FRAC;
   localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

   function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
      mag_w = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   // request fields
   logic [W-1:0]    req_error;
   logic [W-1:0]    req_rate;
   logic [DT_W-1:0] req_dt;
   logic            accept;

   // registers
   logic [W-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff, integ_upper_ff, integ_lower_ff;

   // loop state
   logic [W-1:0] integ_acc_ff, prev_error_ff, deriv_error_ff, prop_error_ff;

   // work registers
   pidc_state_type  state_ff, state_in;
   logic [W-1:0]    err_ff;
   logic [DT_W-1:0] dt_ff;
   logic [OP_W-1:0] op_ff;
   logic [W:0]      diff_ff;
   logic            sgn_i_ff, sgn_p_ff, sgn_d_ff;
   logic [INC_W-1:0]  inc_mag_ff, inc_mag_in;
   logic [PMAG_W-1:0] p_mag_ff, p_mag_in, d_mag_ff;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [PT_W-1:0]   p_term_ff, p_term_in, d_term_ff, d_term_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [W-1:0]      cmd_ff, cmd_in, integ_in, deriv_q_in;
   logic              rsp_valid_ff;
   logic [4*W-1:0]    rsp_data_ff;

   // sequencer controls
   logic mi_start, mpd_start, div_start;
   logic ld_p, ld_inc, ld_d, ld_out;

   // serial units
   logic [MI_A-1:0] mi_a;
   logic [MI_B-1:0] mi_b;
   logic [MI_P-1:0] mi_prod;
   logic            mi_busy;
   logic [W-1:0]    mpd_a, mpd_b;
   logic [PD_P-1:0] mpd_prod;
   logic            mpd_busy;
   logic [N_W-1:0]  div_num, div_quot;
   logic            div_busy;

   // datapath helpers
   logic [W-1:0]     err_mag, der_mag;
   logic [W:0]       diff_mag;
   logic             q_big;
   logic [ACC_W-1:0] integ_x, inc_x, upper_x, lower_x, clamp_hi;
   logic [NEG_W-1:0] sum_x, neg_val;
   logic [NEG_W-W:0] sat_hi;

   assign req_error = req_tdata[W-1:0];
   assign req_rate  = req_tdata[2*W-1:W];
   assign req_dt    = req_tdata[2*W+DT_W-1:2*W];
   assign accept    = req_tvalid & req_tready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= '0;
         integ_gain_ff  <= '0;
         deriv_gain_ff  <= '0;
         integ_upper_ff <= '0;
         integ_lower_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_PROP_GAIN:   prop_gain_ff   <= csr_wdata;
            CSR_INTEG_GAIN:  integ_gain_ff  <= csr_wdata;
            CSR_DERIV_GAIN:  deriv_gain_ff  <= csr_wdata;
            CSR_INTEG_UPPER: integ_upper_ff <= csr_wdata;
            CSR_INTEG_LOWER: integ_lower_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and unit controls
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      mi_start   = 1'b0;
      mpd_start  = 1'b0;
      div_start  = 1'b0;
      ld_p       = 1'b0;
      ld_inc     = 1'b0;
      ld_d       = 1'b0;
      ld_out     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = (req_dt == '0) ? ST_DONE : ST_LOAD;
            end
         end
         ST_LOAD: begin
            mi_start  = 1'b1;
            mpd_start = 1'b1;
            div_start = 1'b1;
            state_in  = ST_MUL1;
         end
         ST_MUL1: begin
            if (!mi_busy && !mpd_busy) begin
               mi_start = 1'b1;
               ld_p     = 1'b1;
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if (!mi_busy && !div_busy) begin
               ld_inc   = 1'b1;
               state_in = ST_DLOAD;
            end
         end
         ST_DLOAD: begin
            mpd_start = 1'b1;
            state_in  = ST_DMUL;
         end
         ST_DMUL: begin
            if (!mpd_busy) begin
               ld_d     = 1'b1;
               state_in = ST_ACC;
            end
         end
         ST_ACC:   state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_SUM;
         ST_SUM:   state_in = ST_CMD;
         ST_CMD:   state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ld_out   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // unit operands: first pass is gain times error, second pass is that times the step
   always_comb begin
      err_mag  = mag_w(err_ff);
      der_mag  = mag_w(deriv_error_ff);
      diff_mag = diff_ff[W] ? (~diff_ff + 1'b1) : diff_ff;
      div_num  = {diff_mag, {DT_FRAC{1'b0}}} + N_W'(dt_ff[DT_W-1:1]);
      if (state_ff == ST_LOAD) begin
         mi_a  = MI_A'(mag_w(integ_gain_ff));
         mi_b  = MI_B'(err_mag);
         mpd_a = mag_w(prop_gain_ff);
         mpd_b = err_mag;
      end else begin
         mi_a  = mi_prod[MI_A-1:0];
         mi_b  = MI_B'(dt_ff);
         mpd_a = mag_w(deriv_gain_ff);
         mpd_b = der_mag;
      end
   end

   pidc_mul #(.A_W(MI_A), .B_W(MI_B)) u_mul_integ (
      .clock   (clock),
      .reset   (reset),
      .start   (mi_start),
      .mcand   (mi_a),
      .mplier  (mi_b),
      .busy    (mi_busy),
      .product (mi_prod)
   );

   pidc_mul #(.A_W(W), .B_W(W)) u_mul_pd (
      .clock   (clock),
      .reset   (reset),
      .start   (mpd_start),
      .mcand   (mpd_a),
      .mplier  (mpd_b),
      .busy    (mpd_busy),
      .product (mpd_prod)
   );

   pidc_div #(.N_W(N_W), .D_W(DT_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (dt_ff),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   // rounding, clamping and command arithmetic
   always_comb begin
      // round half away from zero on magnitudes
      p_mag_in   = PMAG_W'(mpd_prod[PD_P-1:F]) + PMAG_W'(mpd_prod[F-1]);
      inc_mag_in = INC_W'(mi_prod[MI_P-1:INC_S]) + INC_W'(mi_prod[INC_S-1]);

      // difference quotient saturates at the data range
      q_big = |div_quot[N_W-1:W-1];
      if (diff_ff[W]) begin
         deriv_q_in = q_big ? SAT_MIN : (~div_quot[W-1:0] + 1'b1);
      end else begin
         deriv_q_in = q_big ? SAT_MAX : div_quot[W-1:0];
      end

      // integral update
      integ_x = {{(ACC_W-W){integ_acc_ff[W-1]}}, integ_acc_ff};
      inc_x   = ACC_W'(inc_mag_ff);
      acc_in  = integ_x + (sgn_i_ff ? (~inc_x + 1'b1) : inc_x);

      // signed p and d terms
      p_term_in = sgn_p_ff ? (~PT_W'(p_mag_ff) + 1'b1) : PT_W'(p_mag_ff);
      d_term_in = sgn_d_ff ? (~PT_W'(d_mag_ff) + 1'b1) : PT_W'(d_mag_ff);

      // upper limit first, then lower
      upper_x  = {{(ACC_W-W){integ_upper_ff[W-1]}}, integ_upper_ff};
      lower_x  = {{(ACC_W-W){integ_lower_ff[W-1]}}, integ_lower_ff};
      clamp_hi = ($signed(acc_ff) > $signed(upper_x)) ? upper_x : acc_ff;
      integ_in = ($signed(clamp_hi) < $signed(lower_x)) ? lower_x[W-1:0] : clamp_hi[W-1:0];

      sum_in = {{(SUM_W-PT_W){p_term_ff[PT_W-1]}}, p_term_ff}
             + {{(SUM_W-W){integ_acc_ff[W-1]}}, integ_acc_ff}
             + {{(SUM_W-PT_W){d_term_ff[PT_W-1]}}, d_term_ff};

      // optional negation and saturation
      sum_x   = {sum_ff[SUM_W-1], sum_ff};
      neg_val = op_ff[OP_NEG_BIT] ? (~sum_x + 1'b1) : sum_x;
      sat_hi  = neg_val[NEG_W-1:W-1];
      if ((&sat_hi) || !(|sat_hi)) begin
         cmd_in = neg_val[W-1:0];
      end else begin
         cmd_in = neg_val[NEG_W-1] ? SAT_MIN : SAT_MAX;
      end
   end

   // loop state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_acc_ff   <= '0;
         prev_error_ff  <= '0;
         deriv_error_ff <= '0;
         prop_error_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            prop_error_ff <= req_error;
            if (req_tuser[OP_RATE_BIT]) begin
               deriv_error_ff <= req_rate;
            end
         end
         if (ld_inc && !op_ff[OP_RATE_BIT]) begin
            deriv_error_ff <= deriv_q_in;
            prev_error_ff  <= err_ff;
         end
         if (state_ff == ST_CLAMP) begin
            integ_acc_ff <= integ_in;
         end
         if (ld_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff  <= req_error;
         dt_ff   <= req_dt;
         op_ff   <= req_tuser;
         diff_ff <= {req_error[W-1], req_error} - {prev_error_ff[W-1], prev_error_ff};
         cmd_ff  <= '0;
      end
      if (state_ff == ST_LOAD) begin
         sgn_i_ff <= integ_gain_ff[W-1] ^ err_ff[W-1];
         sgn_p_ff <= prop_gain_ff[W-1] ^ err_ff[W-1];
      end
      if (state_ff == ST_DLOAD) begin
         sgn_d_ff <= deriv_gain_ff[W-1] ^ deriv_error_ff[W-1];
      end
      if (ld_p) begin
         p_mag_ff <= p_mag_in;
      end
      if (ld_inc) begin
         inc_mag_ff <= inc_mag_in;
      end
      if (ld_d) begin
         d_mag_ff <= p_mag_in;
      end
      if (state_ff == ST_ACC) begin
         acc_ff    <= acc_in;
         p_term_ff <= p_term_in;
         d_term_ff <= d_term_in;
      end
      if (state_ff == ST_SUM) begin
         sum_ff <= sum_in;
      end
      if (state_ff == ST_CMD) begin
         cmd_ff <= cmd_in;
      end
      if (ld_out) begin
         rsp_data_ff <= {deriv_error_ff, integ_acc_ff, prop_error_ff, cmd_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TD_W'(rsp_data_ff);

endmodule
